>>> rtl/nhor_pkg.sv
// Shared constants, codes, types and width helpers for the nearest-hit search block.
package nhor_pkg;

  // Default geometry widths.
  localparam int COORD_BITS_DEF = 20;
  localparam int IDENT_BITS_DEF = 16;

  // Configuration port layout.
  localparam int VIEW_BITS      = 2;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_VIEW_MODE    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INNER_RADIUS = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTRE_X     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTRE_Y     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTRE_Z     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TOWER_WINDOW = 3'd5;

  // View codes; the spare code selects the full 3-D distance as well.
  localparam logic [VIEW_BITS-1:0] VIEW_X  = 2'd0;
  localparam logic [VIEW_BITS-1:0] VIEW_Y  = 2'd1;
  localparam logic [VIEW_BITS-1:0] VIEW_3D = 2'd2;

  // Far limit: 1e6 mm in 1/16 mm units, and its square.
  localparam int                  CMP_BITS      = 64;
  localparam logic [CMP_BITS-1:0] MAX_RADIUS    = 64'd16000000;
  localparam logic [CMP_BITS-1:0] MAX_RADIUS_SQ = 64'd256000000000000;

  // Operand width that covers any component below the far limit.
  localparam int SQ_LIMIT_BITS = 24;

  function automatic int sq_in_bits(input int coord_bits);
    return (coord_bits < SQ_LIMIT_BITS) ? coord_bits : SQ_LIMIT_BITS;
  endfunction

  // Width of a distance: sum of three squares, wide enough for a 1-D distance too.
  function automatic int dist_bits(input int coord_bits);
    return 2 * sq_in_bits(coord_bits) + 2;
  endfunction

  // Per-stage load enables handed to the datapath pipeline.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } stage_load_t;

endpackage

>>> rtl/nearest_hit_outside_radius.sv
// Top level: nearest qualifying hit of a layer, found outside an inner radius.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------------
//  hit in  | in        | in_valid / in_ready   | hit_x hit_y hit_z hit_flagged hit_ident
//          |           |                       | last_hit
//  result  | out       | out_valid / out_ready | found near_x near_y near_z near_ident
//  config  | in        | cfg_write (no wait)   | cfg_index cfg_data
//
// One hit beat is taken every cycle unless the input is stalled. A layer's result reaches
// the output register through the difference, registered as its last beat is taken, then
// square, sum-and-qualify, and the running-minimum compare that loads the result.
// rst (synchronous) clears the pipeline valids, the running-best flag and the result valid;
// the configuration registers return to zero.
// A held result stalls only a last beat waiting in the final stage; other beats keep
// flowing into the running minimum, and the input stalls once the pipeline fills up.
module nearest_hit_outside_radius #(
  parameter int COORD_BITS = nhor_pkg::COORD_BITS_DEF,
  parameter int IDENT_BITS = nhor_pkg::IDENT_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // hit channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [COORD_BITS-1:0]            hit_x,
  input  logic signed [COORD_BITS-1:0]            hit_y,
  input  logic signed [COORD_BITS-1:0]            hit_z,
  input  logic                                    hit_flagged,
  input  logic [IDENT_BITS-1:0]                   hit_ident,
  input  logic                                    last_hit,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    found,
  output logic signed [COORD_BITS-1:0]            near_x,
  output logic signed [COORD_BITS-1:0]            near_y,
  output logic signed [COORD_BITS-1:0]            near_z,
  output logic [IDENT_BITS-1:0]                   near_ident,
  // configuration port
  input  logic                                    cfg_write,
  input  logic [nhor_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]                   cfg_data
);

  localparam int DW = nhor_pkg::dist_bits(COORD_BITS);
  localparam int RW = COORD_BITS - 1;

  // Configuration registers.
  logic [nhor_pkg::VIEW_BITS-1:0] view_mode;
  logic [RW-1:0]                  inner_radius;
  logic [COORD_BITS-1:0]          centre_x, centre_y, centre_z;
  logic [RW-1:0]                  tower_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_mode    <= '0;
      inner_radius <= '0;
      centre_x     <= '0;
      centre_y     <= '0;
      centre_z     <= '0;
      tower_window <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        nhor_pkg::CFG_VIEW_MODE:    view_mode    <= cfg_data[nhor_pkg::VIEW_BITS-1:0];
        nhor_pkg::CFG_INNER_RADIUS: inner_radius <= cfg_data[RW-1:0];
        nhor_pkg::CFG_CENTRE_X:     centre_x     <= cfg_data;
        nhor_pkg::CFG_CENTRE_Y:     centre_y     <= cfg_data;
        nhor_pkg::CFG_CENTRE_Z:     centre_z     <= cfg_data;
        nhor_pkg::CFG_TOWER_WINDOW: tower_window <= cfg_data[RW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Pipeline occupancy and stage handshake.
  logic v1, v2, v3;
  logic out_free, go3, rdy1, rdy2, rdy3;
  nhor_pkg::stage_load_t ld;

  logic [DW-1:0]         s3_dist;
  logic                  s3_qual, s3_last;
  logic [COORD_BITS-1:0] s3_x, s3_y, s3_z;
  logic [IDENT_BITS-1:0] s3_ident;

  always_comb begin
    out_free = !out_valid || out_ready;
    // A last beat leaves the final stage only when the result register can take it.
    go3      = v3 && (!s3_last || out_free);
    rdy3     = !v3 || go3;
    rdy2     = !v2 || rdy3;
    rdy1     = !v1 || rdy2;
    in_ready = rdy1;
    ld.ld1   = rdy1;
    ld.ld2   = rdy2;
    ld.ld3   = rdy3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  nhor_metric #(
    .COORD_BITS (COORD_BITS),
    .IDENT_BITS (IDENT_BITS)
  ) u_metric (
    .clk          (clk),
    .ld           (ld),
    .view_mode    (view_mode),
    .inner_radius (inner_radius),
    .centre_x     (centre_x),
    .centre_y     (centre_y),
    .centre_z     (centre_z),
    .tower_window (tower_window),
    .hit_x        (hit_x),
    .hit_y        (hit_y),
    .hit_z        (hit_z),
    .hit_flagged  (hit_flagged),
    .hit_ident    (hit_ident),
    .last_hit     (last_hit),
    .s3_dist      (s3_dist),
    .s3_qual      (s3_qual),
    .s3_x         (s3_x),
    .s3_y         (s3_y),
    .s3_z         (s3_z),
    .s3_ident     (s3_ident),
    .s3_last      (s3_last)
  );

  // Running minimum. Strict less-than keeps the earlier hit on a tie.
  logic                  have_best;
  logic [DW-1:0]         best_dist;
  logic [COORD_BITS-1:0] best_x, best_y, best_z;
  logic [IDENT_BITS-1:0] best_ident;
  logic                  take;
  logic                  found_next;

  always_comb begin
    take       = s3_qual && (!have_best || (s3_dist < best_dist));
    found_next = have_best || take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (go3) begin
      if (s3_last) begin
        have_best <= 1'b0;  // start the next layer empty
      end else if (take) begin
        have_best <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go3 && take && !s3_last) begin
      best_dist  <= s3_dist;
      best_x     <= s3_x;
      best_y     <= s3_y;
      best_z     <= s3_z;
      best_ident <= s3_ident;
    end
  end

  // Result register: loads on a last beat, holds until taken. Zero fields when nothing found.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go3 && s3_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go3 && s3_last) begin
      found      <= found_next;
      near_x     <= !found_next ? '0 : (take ? s3_x : best_x);
      near_y     <= !found_next ? '0 : (take ? s3_y : best_y);
      near_z     <= !found_next ? '0 : (take ? s3_z : best_z);
      near_ident <= !found_next ? '0 : (take ? s3_ident : best_ident);
    end
  end

endmodule

>>> rtl/nhor_metric.sv
// Three-stage distance pipeline: differences, squares and qualification.
module nhor_metric #(
  parameter int COORD_BITS = nhor_pkg::COORD_BITS_DEF,
  parameter int IDENT_BITS = nhor_pkg::IDENT_BITS_DEF
) (
  input  logic                                           clk,
  input  nhor_pkg::stage_load_t                          ld,
  input  logic [nhor_pkg::VIEW_BITS-1:0]                 view_mode,
  input  logic [COORD_BITS-2:0]                          inner_radius,
  input  logic [COORD_BITS-1:0]                          centre_x,
  input  logic [COORD_BITS-1:0]                          centre_y,
  input  logic [COORD_BITS-1:0]                          centre_z,
  input  logic [COORD_BITS-2:0]                          tower_window,
  input  logic signed [COORD_BITS-1:0]                   hit_x,
  input  logic signed [COORD_BITS-1:0]                   hit_y,
  input  logic signed [COORD_BITS-1:0]                   hit_z,
  input  logic                                           hit_flagged,
  input  logic [IDENT_BITS-1:0]                          hit_ident,
  input  logic                                           last_hit,
  output logic [nhor_pkg::dist_bits(COORD_BITS)-1:0]     s3_dist,
  output logic                                           s3_qual,
  output logic [COORD_BITS-1:0]                          s3_x,
  output logic [COORD_BITS-1:0]                          s3_y,
  output logic [COORD_BITS-1:0]                          s3_z,
  output logic [IDENT_BITS-1:0]                          s3_ident,
  output logic                                           s3_last
);

  localparam int CB   = COORD_BITS;
  localparam int RW   = COORD_BITS - 1;
  localparam int MW   = nhor_pkg::sq_in_bits(COORD_BITS);
  localparam int DW   = nhor_pkg::dist_bits(COORD_BITS);
  localparam int CMPW = nhor_pkg::CMP_BITS;

  function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic [CB:0] d;
    logic [CB:0] n;
    d = {a[CB-1], a} - {b[CB-1], b};
    n = -d;
    return d[CB] ? n[CB-1:0] : d[CB-1:0];
  endfunction

  // Stage 1: absolute differences.
  logic [CB-1:0] s1_dx, s1_dy, s1_dz;
  logic [CB-1:0] s1_x, s1_y, s1_z;
  logic [IDENT_BITS-1:0] s1_ident;
  logic s1_last, s1_live;

  // Stage 2: squares and the 1-D test.
  logic [2*MW-1:0] s2_sqx, s2_sqy, s2_sqz;
  logic [CB-1:0] s2_meas;
  logic s2_ok1, s2_far, s2_is1d, s2_live, s2_last;
  logic [CB-1:0] s2_x, s2_y, s2_z;
  logic [IDENT_BITS-1:0] s2_ident;

  logic [2*RW-1:0] r_sq;

  logic [CB-1:0] meas, twr;
  logic ok1, far, is1d;
  logic [DW-1:0] sum;
  logic ok3;

  always_comb begin
    is1d = (view_mode == nhor_pkg::VIEW_X) || (view_mode == nhor_pkg::VIEW_Y);
    meas = (view_mode == nhor_pkg::VIEW_Y) ? s1_dy : s1_dx;
    twr  = (view_mode == nhor_pkg::VIEW_Y) ? s1_dx : s1_dy;
    ok1  = s1_live && (meas >= CB'(inner_radius)) && (CMPW'(meas) < nhor_pkg::MAX_RADIUS) &&
           (twr < CB'(tower_window));
    far  = (CMPW'(s1_dx) >= nhor_pkg::MAX_RADIUS) || (CMPW'(s1_dy) >= nhor_pkg::MAX_RADIUS) ||
           (CMPW'(s1_dz) >= nhor_pkg::MAX_RADIUS);
    sum  = DW'(s2_sqx) + DW'(s2_sqy) + DW'(s2_sqz);
    ok3  = s2_live && !s2_far && (CMPW'(sum) >= CMPW'(r_sq)) &&
           (CMPW'(sum) < nhor_pkg::MAX_RADIUS_SQ);
  end

  // The squared radius is registered, so it follows the radius register in the cycle after.
  always_ff @(posedge clk) begin
    r_sq <= inner_radius * inner_radius;
  end

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      s1_dx    <= abs_diff(hit_x, centre_x);
      s1_dy    <= abs_diff(hit_y, centre_y);
      s1_dz    <= abs_diff(hit_z, centre_z);
      s1_x     <= hit_x;
      s1_y     <= hit_y;
      s1_z     <= hit_z;
      s1_ident <= hit_ident;
      s1_last  <= last_hit;
      s1_live  <= !hit_flagged;
    end
    if (ld.ld2) begin
      s2_sqx   <= s1_dx[MW-1:0] * s1_dx[MW-1:0];
      s2_sqy   <= s1_dy[MW-1:0] * s1_dy[MW-1:0];
      s2_sqz   <= s1_dz[MW-1:0] * s1_dz[MW-1:0];
      s2_meas  <= meas;
      s2_ok1   <= ok1;
      s2_far   <= far;
      s2_is1d  <= is1d;
      s2_live  <= s1_live;
      s2_last  <= s1_last;
      s2_x     <= s1_x;
      s2_y     <= s1_y;
      s2_z     <= s1_z;
      s2_ident <= s1_ident;
    end
    if (ld.ld3) begin
      s3_dist  <= s2_is1d ? DW'(s2_meas) : sum;
      s3_qual  <= s2_is1d ? s2_ok1 : ok3;
      s3_last  <= s2_last;
      s3_x     <= s2_x;
      s3_y     <= s2_y;
      s3_z     <= s2_z;
      s3_ident <= s2_ident;
    end
  end

endmodule

>>> rtl/nhor_checker.sv
// Port-level checker for the nearest-hit block, with its bind to the top level.
module nhor_checker #(
  parameter int COORD_BITS = nhor_pkg::COORD_BITS_DEF,
  parameter int IDENT_BITS = nhor_pkg::IDENT_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                found,
  input logic signed [COORD_BITS-1:0]        near_x,
  input logic signed [COORD_BITS-1:0]        near_y,
  input logic signed [COORD_BITS-1:0]        near_z,
  input logic [IDENT_BITS-1:0]               near_ident
);

  // A held result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(near_x) &&
      $stable(near_y) && $stable(near_z) && $stable(near_ident))
    else $error("result beat changed while stalled");

  // An empty search reports a zero position and identifier.
  a_zero_when_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> near_x == '0 && near_y == '0 && near_z == '0 && near_ident == '0)
    else $error("no hit found but result fields are not zero");

  // The input stalls only behind a result that is waiting to be taken.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nearest_hit_outside_radius nhor_checker #(
  .COORD_BITS (COORD_BITS),
  .IDENT_BITS (IDENT_BITS)
) u_nhor_checker (.*);
